>>> rtl/core/dlc_pkg.sv
// Shared types, codes and helpers for the drive link controller.
`default_nettype none
package dlc_pkg;

	typedef enum logic [3:0] {
		MODE_BOOT = 4'b0001,
		MODE_RUN  = 4'b0010,
		MODE_DIS  = 4'b0100,
		MODE_ERR  = 4'b1000
	} mode_t;

	localparam logic [1:0] MODE_CODE_BOOT = 2'd0;
	localparam logic [1:0] MODE_CODE_RUN  = 2'd1;
	localparam logic [1:0] MODE_CODE_DIS  = 2'd2;
	localparam logic [1:0] MODE_CODE_ERR  = 2'd3;

	localparam logic [1:0] LED_OFF  = 2'd0;
	localparam logic [1:0] LED_ON   = 2'd1;
	localparam logic [1:0] LED_KEEP = 2'd2;

	localparam logic [1:0] REG_HB_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_DIS_ON     = 2'd1;
	localparam logic [1:0] REG_DIS_PERIOD = 2'd2;
	localparam logic [1:0] REG_ERR_TOGGLE = 2'd3;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;

	typedef struct packed {
		logic [15:0] hb_timeout;
		logic [15:0] dis_on;
		logic [15:0] dis_period;
		logic [15:0] err_toggle;
	} cfg_t;

	// one item as taken from the input register
	typedef struct packed {
		logic       actuator_ok;
		logic       init_ok;
		logic [7:0] rx_byte;
		logic       rx_valid;
		logic       tick;
	} item_t;

	// line parser -> mode control, for the byte of this item
	typedef struct packed {
		logic        speed;
		logic        heartbeat;
		logic [15:0] left;
		logic [15:0] right;
	} line_evt_t;

	// mode control -> line parser
	typedef struct packed {
		logic byte_en;
		logic clear;
	} line_ctl_t;

	typedef struct packed {
		logic [15:0] pwm_right;
		logic [15:0] pwm_left;
		logic        pwm_write;
		logic [1:0]  led_drive;
		logic [1:0]  mode_now;
	} result_t;

	function automatic logic [1:0] mode_code(input mode_t m);
		logic [1:0] r;
		case (m)
			MODE_BOOT: r = MODE_CODE_BOOT;
			MODE_RUN:  r = MODE_CODE_RUN;
			MODE_DIS:  r = MODE_CODE_DIS;
			default:   r = MODE_CODE_ERR;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/drive_link_controller.sv
// Drive link controller: input register, mode and line logic, result register.
// Path: input register, then mode and line logic, then the result register.
// One word per cycle unless stalled; input register refills while a result waits.
// Mode, counter and line state update once per word, as the result register loads.
// Reset (arst_n low, asynchronous): boot mode, counters and line cleared,
// registers at their defaults, both stages empty.
`default_nettype none
module drive_link_controller
	import dlc_pkg::*;
#(
	parameter int LINE_BUFFER_BYTES = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// tick[0], rx_valid[1], rx_byte[9:2], init_ok[10], actuator_ok[11], zero[15:12]
	input  wire logic [15:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// mode_now[1:0], led_drive[3:2], pwm_write[4], pwm_left[20:5], pwm_right[36:21],
	// zero[39:37]
	output logic [39:0]      m_tdata,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	cfg_t      cfg_q;
	item_t     item_s1;
	logic      valid_s1;
	logic      adv;
	line_ctl_t ctl;
	line_evt_t evt;
	result_t   res;
	result_t   res_q;

	assign adv      = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hb_timeout <= 16'd500;
			cfg_q.dis_on     <= 16'd100;
			cfg_q.dis_period <= 16'd1000;
			cfg_q.err_toggle <= 16'd250;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HB_TIMEOUT: cfg_q.hb_timeout <= cfg_data;
				REG_DIS_ON:     cfg_q.dis_on     <= cfg_data;
				REG_DIS_PERIOD: cfg_q.dis_period <= cfg_data;
				REG_ERR_TOGGLE: cfg_q.err_toggle <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tvalid && s_tready)
			valid_s1 <= 1'b1;
		else if (adv)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			item_s1 <= s_tdata[11:0];
	end

	dlc_line_parser #(
		.LINE_BUFFER_BYTES(LINE_BUFFER_BYTES)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.ctl    (ctl),
		.rx_byte(item_s1.rx_byte),
		.evt    (evt)
	);

	dlc_mode_ctrl u_mode (
		.clk   (clk),
		.arst_n(arst_n),
		.adv   (adv),
		.item  (item_s1),
		.cfg   (cfg_q),
		.evt   (evt),
		.ctl   (ctl),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (adv)
			m_tvalid <= 1'b1;
		else if (m_tready)
			m_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_q <= res;
	end

	assign m_tdata = {3'b000, res_q};

	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> m_tvalid)
		else $error("result word lost after stage advance");

	a_stall_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while both stages are full");

	a_no_pwm_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[4] |-> m_tdata[36:5] == 32'd0)
		else $error("nonzero pwm without pwm_write");

	a_led_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[3:2] != 2'b11)
		else $error("bad led_drive code");

endmodule
`default_nettype wire

>>> rtl/core/dlc_line_parser.sv
// Incremental command line parser: length, comma, heartbeat mark and two numbers.
`default_nettype none
module dlc_line_parser
	import dlc_pkg::*;
#(
	parameter int LINE_BUFFER_BYTES = 64
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      adv,
	input  wire line_ctl_t ctl,
	input  wire logic [7:0] rx_byte,
	output line_evt_t      evt
);

	localparam int CW = $clog2(LINE_BUFFER_BYTES);
	localparam logic [CW-1:0] LAST = CW'(LINE_BUFFER_BYTES - 1);

	localparam logic [1:0] PH_SKIP   = 2'd0;
	localparam logic [1:0] PH_SIGN   = 2'd1;
	localparam logic [1:0] PH_DIGITS = 2'd2;
	localparam logic [1:0] PH_DONE   = 2'd3;

	logic [CW-1:0] lc_q, tl_q, n_lc, n_tl;
	logic          ended_q, first_h_q, comma_q, n_ended, n_first_h, n_comma;
	logic [1:0]    lph_q, rph_q, n_lph, n_rph;
	logic [16:0]   lval_q, rval_q, n_lval, n_rval;
	logic          wipe;

	// strtol-style digit accumulation; value is {sign, magnitude}
	function automatic logic [18:0] num_feed(input logic [1:0] ph, input logic [16:0] v,
			input logic [7:0] c);
		logic        dig, sp;
		logic [15:0] mag;
		logic [18:0] r;
		dig = (c >= CH_0) && (c <= CH_9);
		sp  = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
		mag = 16'({v[12:0], 3'b000} + {v[14:0], 1'b0} + {12'd0, c[3:0]});
		r   = {PH_DONE, v};
		if (ph == PH_SKIP && sp)
			r = {ph, v};
		else if (ph == PH_SKIP && (c == CH_PLUS || c == CH_MINUS))
			r = {PH_SIGN, (c == CH_MINUS), 16'd0};
		else if (ph != PH_DONE && dig)
			r = {PH_DIGITS, v[16], mag};
		return r;
	endfunction

	function automatic logic [15:0] num_value(input logic [16:0] v);
		return v[16] ? 16'(16'd0 - v[15:0]) : v[15:0];
	endfunction

	always_comb begin
		n_lc      = lc_q;
		n_tl      = tl_q;
		n_ended   = ended_q;
		n_first_h = first_h_q;
		n_comma   = comma_q;
		n_lph     = lph_q;
		n_lval    = lval_q;
		n_rph     = rph_q;
		n_rval    = rval_q;
		wipe      = 1'b0;
		evt       = '0;
		if (ctl.clear) begin
			wipe = 1'b1;
		end else if (ctl.byte_en) begin
			if (lc_q >= LAST) begin
				wipe = 1'b1;
			end else begin
				if (!ended_q) begin
					if (rx_byte == CH_NUL) begin
						n_ended = 1'b1;
					end else begin
						if (tl_q == '0 && rx_byte == CH_H)
							n_first_h = 1'b1;
						n_tl = tl_q + 1'b1;
						{n_lph, n_lval} = num_feed(lph_q, lval_q, rx_byte);
						if (comma_q)
							{n_rph, n_rval} = num_feed(rph_q, rval_q, rx_byte);
						else if (rx_byte == CH_COMMA)
							n_comma = 1'b1;
					end
				end
				n_lc = lc_q + 1'b1;
				if (rx_byte == CH_LF) begin
					if (n_tl >= CW'(8) && n_tl <= CW'(10) && n_comma) begin
						evt.speed = 1'b1;
						evt.left  = num_value(n_lval);
						evt.right = num_value(n_rval);
					end else if (n_first_h) begin
						evt.heartbeat = 1'b1;
					end
					wipe = 1'b1;
				end
			end
		end
		if (wipe) begin
			n_lc      = '0;
			n_tl      = '0;
			n_ended   = 1'b0;
			n_first_h = 1'b0;
			n_comma   = 1'b0;
			n_lph     = PH_SKIP;
			n_lval    = '0;
			n_rph     = PH_SKIP;
			n_rval    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lc_q      <= '0;
			tl_q      <= '0;
			ended_q   <= 1'b0;
			first_h_q <= 1'b0;
			comma_q   <= 1'b0;
			lph_q     <= PH_SKIP;
			lval_q    <= '0;
			rph_q     <= PH_SKIP;
			rval_q    <= '0;
		end else if (adv) begin
			lc_q      <= n_lc;
			tl_q      <= n_tl;
			ended_q   <= n_ended;
			first_h_q <= n_first_h;
			comma_q   <= n_comma;
			lph_q     <= n_lph;
			lval_q    <= n_lval;
			rph_q     <= n_rph;
			rval_q    <= n_rval;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/dlc_mode_ctrl.sv
// Mode state machine, millisecond counters, LED and PWM result logic.
`default_nettype none
module dlc_mode_ctrl
	import dlc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      adv,
	input  wire item_t     item,
	input  wire cfg_t      cfg,
	input  wire line_evt_t evt,
	output line_ctl_t      ctl,
	output result_t        res
);

	mode_t       mode_q, n_mode;
	logic [15:0] sh_q, sb_q, sh_t, sb_t, n_sh, n_sb;
	logic        eled_q, n_eled;
	logic        hb_lost;

	// counters step before the rest of the item, saturating
	assign sh_t = (item.tick && sh_q != 16'hFFFF) ? sh_q + 16'd1 : sh_q;
	assign sb_t = (item.tick && sb_q != 16'hFFFF) ? sb_q + 16'd1 : sb_q;

	assign hb_lost = sh_t > cfg.hb_timeout;

	// parser control kept apart from the event logic: {byte_en, clear}
	assign ctl = {(mode_q == MODE_RUN) && !hb_lost && item.rx_valid,
		(mode_q == MODE_RUN) && hb_lost};

	always_comb begin
		n_mode        = mode_q;
		n_sh          = sh_t;
		n_sb          = sb_t;
		n_eled        = eled_q;
		res.led_drive = LED_KEEP;
		res.pwm_write = 1'b0;
		res.pwm_left  = '0;
		res.pwm_right = '0;
		case (mode_q)
			MODE_BOOT: begin
				n_mode = item.init_ok ? MODE_RUN : MODE_ERR;
			end
			MODE_RUN: begin
				if (hb_lost) begin
					n_mode = MODE_DIS;
				end else begin
					res.led_drive = LED_ON;
					if (evt.speed) begin
						res.pwm_write = 1'b1;
						res.pwm_left  = evt.left;
						res.pwm_right = evt.right;
						if (!item.actuator_ok)
							n_mode = MODE_ERR;
					end else if (evt.heartbeat) begin
						n_sh = '0;
					end
				end
			end
			MODE_DIS: begin
				res.pwm_write = 1'b1;
				if (item.rx_valid && item.rx_byte == CH_H) begin
					n_sh   = '0;
					n_mode = MODE_RUN;
				end
				if (sb_t > cfg.dis_period)
					n_sb = '0;
				else if (sb_t > cfg.dis_on)
					res.led_drive = LED_OFF;
				else
					res.led_drive = LED_ON;
			end
			default: begin
				res.pwm_write = 1'b1;
				if (sb_t > cfg.err_toggle) begin
					n_eled        = ~eled_q;
					res.led_drive = eled_q ? LED_OFF : LED_ON;
					n_sb          = '0;
				end
			end
		endcase
		res.mode_now = mode_code(n_mode);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BOOT;
			sh_q   <= '0;
			sb_q   <= '0;
			eled_q <= 1'b0;
		end else if (adv) begin
			mode_q <= n_mode;
			sh_q   <= n_sh;
			sb_q   <= n_sb;
			eled_q <= n_eled;
		end
	end

endmodule
`default_nettype wire

>>> bench/tb_drive_link_controller.sv
// Self-checking bench for drive_link_controller: command lines, heartbeat, blink and error modes.
import dlc_pkg::*;

typedef enum logic [1:0] {NUM_SKIP, NUM_SIGNED, NUM_DIGITS, NUM_DONE} num_phase_t;

localparam logic [7:0] CH_TAB   = 8'h09;
localparam logic [7:0] CH_VT    = 8'h0B;
localparam logic [7:0] CH_FF    = 8'h0C;
localparam logic [7:0] CH_CR    = 8'h0D;
localparam logic [7:0] CH_SPACE = 8'h20;
localparam int LINE_BYTES = 64;

// Tracks the controller state per accepted call and holds the result words still due.
class call_tracker;
	logic [15:0] hb_timeout, dis_on, dis_period, err_toggle;
	logic [1:0]  mode;
	logic [15:0] since_hb, since_blink;
	logic        err_led;
	int          line_count, text_len;
	bit          text_ended, first_h, comma_seen;
	num_phase_t  left_ph, right_ph;
	logic [16:0] left_acc, right_acc;
	result_t     due_words[$];
	int          mismatches;
	int          words_seen;

	function new();
		hb_timeout = 16'd500;
		dis_on = 16'd100;
		dis_period = 16'd1000;
		err_toggle = 16'd250;
		mode = MODE_CODE_BOOT;
		since_hb = '0;
		since_blink = '0;
		err_led = 1'b0;
		mismatches = 0;
		words_seen = 0;
		drop_line();
	endfunction

	function void write_reg(logic [1:0] idx, logic [15:0] v);
		case (idx)
			REG_HB_TIMEOUT: hb_timeout = v;
			REG_DIS_ON:     dis_on = v;
			REG_DIS_PERIOD: dis_period = v;
			default:        err_toggle = v;
		endcase
	endfunction

	function void drop_line();
		line_count = 0;
		text_len = 0;
		text_ended = 1'b0;
		first_h = 1'b0;
		comma_seen = 1'b0;
		left_ph = NUM_SKIP;
		right_ph = NUM_SKIP;
		left_acc = '0;
		right_acc = '0;
	endfunction

	function bit is_blank(logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	// accumulator: bit 16 sign, bits 15:0 magnitude wrapping at 16 bits
	function void feed(inout num_phase_t ph, inout logic [16:0] acc, input logic [7:0] c);
		if (ph == NUM_SKIP) begin
			if (is_blank(c)) return;
			if (c == CH_PLUS || c == CH_MINUS) begin
				acc = (c == CH_MINUS) ? 17'h10000 : 17'h00000;
				ph = NUM_SIGNED;
				return;
			end
		end
		if (ph != NUM_DONE && c >= CH_0 && c <= CH_9) begin
			acc[15:0] = acc[15:0] * 16'd10 + 16'(c - CH_0);
			ph = NUM_DIGITS;
			return;
		end
		ph = NUM_DONE;
	endfunction

	function logic [15:0] signed_value(logic [16:0] acc);
		return acc[16] ? 16'd0 - acc[15:0] : acc[15:0];
	endfunction

	function int pending();
		return due_words.size();
	endfunction

	function void take_call(item_t it);
		result_t w;
		w = '0;
		w.led_drive = LED_KEEP;
		if (it.tick) begin
			if (since_hb != 16'hFFFF) since_hb++;
			if (since_blink != 16'hFFFF) since_blink++;
		end
		case (mode)
			MODE_CODE_BOOT: mode = it.init_ok ? MODE_CODE_RUN : MODE_CODE_ERR;
			MODE_CODE_RUN: begin
				if (since_hb > hb_timeout) begin
					mode = MODE_CODE_DIS;
					drop_line();
				end else begin
					w.led_drive = LED_ON;
					if (it.rx_valid && line_count + 1 >= LINE_BYTES) begin
						drop_line();
					end else if (it.rx_valid) begin
						if (!text_ended) begin
							if (it.rx_byte == CH_NUL) begin
								text_ended = 1'b1;
							end else begin
								if (text_len == 0 && it.rx_byte == CH_H) first_h = 1'b1;
								text_len++;
								feed(left_ph, left_acc, it.rx_byte);
								if (comma_seen) feed(right_ph, right_acc, it.rx_byte);
								else if (it.rx_byte == CH_COMMA) comma_seen = 1'b1;
							end
						end
						line_count++;
						if (it.rx_byte == CH_LF) begin
							if (text_len >= 8 && text_len <= 10 && comma_seen) begin
								w.pwm_write = 1'b1;
								w.pwm_left = signed_value(left_acc);
								w.pwm_right = signed_value(right_acc);
								if (!it.actuator_ok) mode = MODE_CODE_ERR;
							end else if (first_h) begin
								since_hb = '0;
							end
							drop_line();
						end
					end
				end
			end
			MODE_CODE_DIS: begin
				w.pwm_write = 1'b1;
				if (it.rx_valid && it.rx_byte == CH_H) begin
					since_hb = '0;
					mode = MODE_CODE_RUN;
				end
				if (since_blink > dis_period) since_blink = '0;
				else if (since_blink > dis_on) w.led_drive = LED_OFF;
				else w.led_drive = LED_ON;
			end
			default: begin
				w.pwm_write = 1'b1;
				if (since_blink > err_toggle) begin
					err_led = !err_led;
					w.led_drive = err_led ? LED_ON : LED_OFF;
					since_blink = '0;
				end
			end
		endcase
		w.mode_now = mode;
		due_words.push_back(w);
	endfunction

	function void match_word(logic [39:0] word);
		result_t got, want;
		got = word[36:0];
		words_seen++;
		if (due_words.size() == 0) begin
			$error("result word %h arrived with nothing expected", word);
			mismatches++;
			return;
		end
		want = due_words.pop_front();
		if (got.mode_now != want.mode_now) begin
			$error("mode_now: expected %0d, got %0d", want.mode_now, got.mode_now);
			mismatches++;
		end
		if (got.led_drive != want.led_drive) begin
			$error("led_drive: expected %0d, got %0d", want.led_drive, got.led_drive);
			mismatches++;
		end
		if (got.pwm_write != want.pwm_write) begin
			$error("pwm_write: expected %0d, got %0d", want.pwm_write, got.pwm_write);
			mismatches++;
		end
		if (got.pwm_left != want.pwm_left) begin
			$error("pwm_left: expected %0d, got %0d",
				$signed(want.pwm_left), $signed(got.pwm_left));
			mismatches++;
		end
		if (got.pwm_right != want.pwm_right) begin
			$error("pwm_right: expected %0d, got %0d",
				$signed(want.pwm_right), $signed(got.pwm_right));
			mismatches++;
		end
	endfunction
endclass

module tb_drive_link_controller;
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// tick[0], rx_valid[1], rx_byte[9:2], init_ok[10], actuator_ok[11], zero[15:12]
	logic [15:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// mode_now[1:0], led_drive[3:2], pwm_write[4], pwm_left[20:5], pwm_right[36:21],
	// zero[39:37]
	logic [39:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	call_tracker tracker;
	int          burst_left = 0;
	int          tick_pct = 50;
	int          calls_sent = 0;
	bit          lf_fails = 1'b0;
	logic [7:0]  line_bytes[$];

	drive_link_controller #(.LINE_BUFFER_BYTES(LINE_BYTES)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) tracker.match_word(m_tdata);
	end

	// output side: stall styles chosen at random in turn, plus one long hold-off
	initial begin
		int style, style_left;
		bit held;
		style = 0;
		style_left = 0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && tracker.words_seen >= 300) begin
				m_tready <= 1'b0;
				repeat (400) @(negedge clk);
				held = 1'b1;
			end
			if (style_left == 0) begin
				style = $urandom_range(0, 2);
				style_left = $urandom_range(16, 80);
			end
			style_left--;
			case (style)
				0:       m_tready <= 1'b1;
				1:       m_tready <= ($urandom_range(0, 3) != 0);
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	initial begin
		#5000000;
		$display("[drive_link_controller] ERROR");
		$finish;
	end

	function automatic logic [7:0] blank_char();
		logic [7:0] c;
		case ($urandom_range(0, 4))
			0:       c = CH_SPACE;
			1:       c = CH_TAB;
			2:       c = CH_VT;
			3:       c = CH_FF;
			default: c = CH_CR;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] printable();
		return 8'($urandom_range(8'h20, 8'h7E));
	endfunction

	function automatic void add_number();
		int n;
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
		repeat (n) line_bytes.push_back(blank_char());
		case ($urandom_range(0, 2))
			0:       line_bytes.push_back(CH_PLUS);
			1:       line_bytes.push_back(CH_MINUS);
			default: ;
		endcase
		n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
		repeat (n) line_bytes.push_back(8'(CH_0 + $urandom_range(0, 9)));
	endfunction

	// left,right padded toward the 8..10 character window
	function automatic void build_speed_line();
		int target;
		add_number();
		line_bytes.push_back(CH_COMMA);
		add_number();
		target = $urandom_range(7, 11);
		while (line_bytes.size() < target) line_bytes.push_back(printable());
		line_bytes.push_back(CH_LF);
	endfunction

	task automatic send_item(input item_t it);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0000, it};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tracker.take_call(it);
		burst_left--;
		calls_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b, input bit rxv);
		item_t it;
		it.tick = ($urandom_range(0, 99) < tick_pct);
		it.rx_valid = rxv;
		it.rx_byte = b;
		it.init_ok = 1'($urandom_range(0, 1));
		// actuator status only counts on a newline; a failure there is permanent
		it.actuator_ok = (rxv && b == CH_LF) ? !lf_fails : 1'($urandom_range(0, 1));
		send_item(it);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b1);
	endtask

	task automatic send_line();
		int kind;
		line_bytes.delete();
		kind = $urandom_range(0, 99);
		if (kind < 40) begin
			build_speed_line();
		end else if (kind < 50) begin
			// NUL ends the counted text early, newline still closes the line
			build_speed_line();
			line_bytes.insert($urandom_range(0, line_bytes.size() - 1), CH_NUL);
		end else if (kind < 65) begin
			line_bytes.push_back(CH_H);
			repeat ($urandom_range(0, 9)) line_bytes.push_back(printable());
			line_bytes.push_back(CH_LF);
		end else if (kind < 75) begin
			repeat ($urandom_range(0, 14))
				line_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : printable());
			line_bytes.push_back(CH_LF);
		end else if (kind < 78) begin
			repeat ($urandom_range(60, 75)) line_bytes.push_back(printable());
			line_bytes.push_back(CH_LF);
		end else if (kind < 90) begin
			line_bytes.push_back(8'($urandom));
		end else begin
			send_byte(8'($urandom), 1'b0);
		end
		foreach (line_bytes[i]) begin
			if ($urandom_range(0, 9) == 0) send_byte(8'($urandom), 1'b0);
			send_byte(line_bytes[i], 1'b1);
		end
	endtask

	task automatic run_phase(input int count, input int pct, input bit any_bytes);
		int stop;
		tick_pct = pct;
		stop = calls_sent + count;
		while (calls_sent < stop) begin
			if (any_bytes) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
			else send_line();
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		tracker.write_reg(idx, v);
	endtask

	task automatic set_config(input logic [15:0] hb, on, per, tog);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		write_reg(REG_HB_TIMEOUT, hb);
		write_reg(REG_DIS_ON, on);
		write_reg(REG_DIS_PERIOD, per);
		write_reg(REG_ERR_TOGGLE, tog);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		item_t first_call;
		tracker = new();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_config(16'd60000, 16'd0, 16'd1, 16'd1);
		first_call.tick = 1'b1;
		first_call.rx_valid = 1'b1;
		first_call.rx_byte = 8'hFF;
		first_call.init_ok = 1'b1;
		first_call.actuator_ok = 1'b0;
		send_item(first_call);
		send_text("99999,-1\n");
		send_text("+,-\t\t\t\t\t\n");
		send_text("H\n");
		send_byte(8'h00, 1'b0);
		run_phase(250, 50, 1'b0);

		// heartbeat of one ms: mostly disabled, H bytes bring it back
		set_config(16'd1, 16'd0, 16'd1, 16'd60000);
		run_phase(250, 30, 1'b0);
		set_config(16'($urandom_range(4, 60)), 16'($urandom_range(0, 15)),
			16'($urandom_range(1, 30)), 16'd1);
		run_phase(250, 60, 1'b0);
		set_config(16'd30, 16'd60000, 16'd60000, 16'd60000);
		run_phase(200, 100, 1'b0);
		set_config(16'($urandom_range(4, 60)), 16'($urandom_range(0, 40)),
			16'($urandom_range(1, 40)), 16'($urandom_range(1, 20)));
		run_phase(250, $urandom_range(20, 100), 1'b0);

		// error mode is terminal, so it comes last
		set_config(16'd60000, 16'($urandom_range(0, 40)), 16'($urandom_range(1, 40)), 16'd1);
		tick_pct = 0;
		send_text("\nH\n");
		lf_fails = 1'b1;
		send_text("10,-20  \n");
		lf_fails = 1'b0;
		run_phase(120, 100, 1'b1);
		set_config(16'd60000, 16'd100, 16'd1000, 16'($urandom_range(2, 12)));
		run_phase(120, 70, 1'b1);
		set_config(16'd60000, 16'd0, 16'd1, 16'd60000);
		run_phase(60, 100, 1'b1);

		@(negedge clk);
		s_tvalid <= 1'b0;
		for (int w = 0; w < 20000 && tracker.pending() != 0; w++) @(negedge clk);
		if (tracker.pending() != 0) begin
			$error("%0d result words never arrived", tracker.pending());
			tracker.mismatches++;
		end
		repeat (10) @(negedge clk);
		if (tracker.mismatches == 0) $display("[drive_link_controller] OK");
		else $display("[drive_link_controller] ERROR");
		$finish;
	end
endmodule
